FILE: src/sts_pkg.sv
// Shared types and constants for the SQL token scanner.
package sts_pkg;

  // Input item: action plus raw character byte.
  typedef struct packed {
    logic       action;
    logic [7:0] char_byte;
  } sts_in_t;

  // Result item fields.
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [62:0] int_value;
    logic [59:0] frac_value;
    logic [4:0]  frac_digits;
    logic [2:0]  error_code;
    logic        last;
  } sts_out_t;

  // Action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Token kinds.
  localparam logic [5:0] TK_EOF    = 6'd0;
  localparam logic [5:0] TK_COMMA  = 6'd1;
  localparam logic [5:0] TK_DOT    = 6'd2;
  localparam logic [5:0] TK_LPAR   = 6'd3;
  localparam logic [5:0] TK_RPAR   = 6'd4;
  localparam logic [5:0] TK_PLUS   = 6'd5;
  localparam logic [5:0] TK_MINUS  = 6'd6;
  localparam logic [5:0] TK_STAR   = 6'd7;
  localparam logic [5:0] TK_SLASH  = 6'd8;
  localparam logic [5:0] TK_EQ     = 6'd9;
  localparam logic [5:0] TK_LT     = 6'd10;
  localparam logic [5:0] TK_LE     = 6'd11;
  localparam logic [5:0] TK_NE     = 6'd12;
  localparam logic [5:0] TK_GT     = 6'd13;
  localparam logic [5:0] TK_GE     = 6'd14;
  localparam logic [5:0] TK_STRING = 6'd15;
  localparam logic [5:0] TK_INT    = 6'd16;
  localparam logic [5:0] TK_DEC    = 6'd17;
  localparam logic [5:0] TK_IDENT  = 6'd18;
  localparam logic [5:0] TK_KW0    = 6'd19;

  // Error codes.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_BANG  = 3'd1;
  localparam logic [2:0] ERR_STR   = 3'd2;
  localparam logic [2:0] ERR_CHAR  = 3'd3;
  localparam logic [2:0] ERR_OVF   = 3'd4;

  // Characters.
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;

  localparam logic [62:0] I64_LIMIT = {63{1'b1}};
  localparam logic [63:0] INT_GUARD = 64'd922337203685477580;

  // Keyword table, packed big-endian in 64 bits.
  localparam int KwCount = 23;
  typedef logic [63:0] kw_arr_t [KwCount];
  localparam kw_arr_t KW_TEXT = '{
    64'h53454C454354, 64'h46524F4D, 64'h5748455245, 64'h4A4F494E,
    64'h494E4E4552, 64'h4C454654, 64'h5249474854, 64'h43524F5353,
    64'h4F4E, 64'h414E44, 64'h4F52, 64'h4E4F54, 64'h4153,
    64'h4F52444552, 64'h4259, 64'h47524F5550, 64'h4C494D4954,
    64'h415343, 64'h44455343, 64'h484156494E47, 64'h4E554C4C,
    64'h54525545, 64'h46414C5345};

  // Scanner modes, one-hot.
  typedef enum logic [9:0] {
    M_IDLE   = 10'b0000000001,
    M_LT     = 10'b0000000010,
    M_GT     = 10'b0000000100,
    M_BANG   = 10'b0000001000,
    M_STRING = 10'b0000010000,
    M_INT    = 10'b0000100000,
    M_INTDOT = 10'b0001000000,
    M_FRAC   = 10'b0010000000,
    M_WORD   = 10'b0100000000,
    M_DEAD   = 10'b1000000000
  } mode_t;

  // Token request from the front to the back: up to three per item.
  typedef struct packed {
    logic        vld;
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic        use_num;
    logic [2:0]  err;
  } tok_req_t;

  // Classification of one byte.
  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
  endfunction

endpackage

FILE: src/sts_front.sv
// Front end: tracks the scanner mode and turns each item into token requests.
module sts_front #(
  parameter int OFFSET_BITS       = 16,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sts_pkg::sts_in_t  in_data,
  output logic              q_push,
  output sts_pkg::tok_req_t q_req [3],
  output logic [62:0]       q_ival,
  output logic [59:0]       q_fval,
  output logic [4:0]        q_fcnt,
  input  logic              q_room
);
  import sts_pkg::*;

  localparam int WbBits = 8 * KEYWORD_MAX_CHARS;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, tstart_r, tstart_nxt;
  logic [63:0]            iacc_r, iacc_nxt, facc_r, facc_nxt;
  logic [4:0]             fcnt_r, fcnt_nxt;
  logic [WbBits-1:0]      wbuf_r, wbuf_nxt;
  logic                   wlong_r, wlong_nxt, ovf_r, ovf_nxt;

  logic                   fire;
  logic [7:0]             b;
  logic [3:0]             d;
  logic [OFFSET_BITS-1:0] p, len, pm1;
  logic [5:0]             kw_kind;
  logic [63:0]            iacc_x10;
  logic [63:0]            facc_x10;
  tok_req_t               r [3];
  logic [1:0]             n;

  assign in_ready = q_room;
  assign fire     = in_valid && in_ready;
  assign b        = in_data.char_byte;
  assign d        = b[3:0] - 4'd0;
  assign p        = pos_r;
  assign pm1      = p - OFFSET_BITS'(1);
  assign len      = p - tstart_r;
  assign iacc_x10 = (iacc_r << 3) + (iacc_r << 1);
  assign facc_x10 = (facc_r << 3) + (facc_r << 1);

  // Keyword match over the packed word buffer.
  always_comb begin
    kw_kind = TK_IDENT;
    if (!wlong_r) begin
      for (int k = KwCount - 1; k >= 0; k--) begin
        if (KW_TEXT[k] == 64'(wbuf_r)) kw_kind = TK_KW0 + 6'(k);
      end
    end
  end

  // One scanner step per accepted item.
  always_comb begin
    logic restart;
    restart    = 1'b0;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    iacc_nxt   = iacc_r;
    facc_nxt   = facc_r;
    fcnt_nxt   = fcnt_r;
    wbuf_nxt   = wbuf_r;
    wlong_nxt  = wlong_r;
    ovf_nxt    = ovf_r;
    n          = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;

    if (in_data.action == ACT_END) begin
      // Flush the pending token, then eof unless an error ended it.
      priority case (1'b1)
        mode_r == M_LT: begin
          r[0] = '{1'b1, TK_LT, 32'(tstart_r), 32'd1, 1'b0, ERR_NONE}; n = 2'd1;
        end
        mode_r == M_GT: begin
          r[0] = '{1'b1, TK_GT, 32'(tstart_r), 32'd1, 1'b0, ERR_NONE}; n = 2'd1;
        end
        mode_r == M_BANG: begin
          r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'd1, 1'b0, ERR_BANG}; n = 2'd3;
        end
        mode_r == M_STRING: begin
          r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'(len), 1'b0, ERR_STR}; n = 2'd3;
        end
        mode_r == M_INT: begin
          if (ovf_r) begin
            r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'(len), 1'b0, ERR_OVF}; n = 2'd3;
          end else begin
            r[0] = '{1'b1, TK_INT, 32'(tstart_r), 32'(len), 1'b1, ERR_NONE}; n = 2'd1;
          end
        end
        mode_r == M_INTDOT: begin
          if (ovf_r) begin
            r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'(OFFSET_BITS'(pm1 - tstart_r)),
                     1'b0, ERR_OVF};
            n = 2'd3;
          end else begin
            r[0] = '{1'b1, TK_INT, 32'(tstart_r), 32'(OFFSET_BITS'(pm1 - tstart_r)),
                     1'b1, ERR_NONE};
            r[1] = '{1'b1, TK_DOT, 32'(pm1), 32'd1, 1'b0, ERR_NONE};
            n = 2'd2;
          end
        end
        mode_r == M_FRAC: begin
          r[0] = '{1'b1, TK_DEC, 32'(tstart_r), 32'(len), 1'b1, ERR_NONE}; n = 2'd1;
        end
        mode_r == M_WORD: begin
          r[0] = '{1'b1, kw_kind, 32'(tstart_r), 32'(len), 1'b0, ERR_NONE}; n = 2'd1;
        end
        mode_r == M_DEAD: n = 2'd3;
        default: n = 2'd0;
      endcase
      if (n != 2'd3) r[n] = '{1'b1, TK_EOF, 32'(p), 32'd0, 1'b0, ERR_NONE};
      mode_nxt = M_IDLE; pos_nxt = '0; tstart_nxt = '0; iacc_nxt = '0;
      facc_nxt = '0; fcnt_nxt = '0; wbuf_nxt = '0; wlong_nxt = 1'b0; ovf_nxt = 1'b0;
    end else begin
      pos_nxt = pos_r + OFFSET_BITS'(1);
      priority case (1'b1)
        mode_r == M_IDLE: restart = 1'b1;
        mode_r == M_LT: begin
          mode_nxt = M_IDLE;
          if (b == CH_EQ) begin
            r[0] = '{1'b1, TK_LE, 32'(tstart_r), 32'd2, 1'b0, ERR_NONE}; n = 2'd1;
          end else if (b == CH_GT) begin
            r[0] = '{1'b1, TK_NE, 32'(tstart_r), 32'd2, 1'b0, ERR_NONE}; n = 2'd1;
          end else begin
            r[0] = '{1'b1, TK_LT, 32'(tstart_r), 32'd1, 1'b0, ERR_NONE}; n = 2'd1;
            restart = 1'b1;
          end
        end
        mode_r == M_GT: begin
          mode_nxt = M_IDLE;
          r[0] = '{1'b1, (b == CH_EQ) ? TK_GE : TK_GT, 32'(tstart_r),
                   (b == CH_EQ) ? 32'd2 : 32'd1, 1'b0, ERR_NONE};
          n = 2'd1;
          restart = b != CH_EQ;
        end
        mode_r == M_BANG: begin
          if (b == CH_EQ) begin
            mode_nxt = M_IDLE;
            r[0] = '{1'b1, TK_NE, 32'(tstart_r), 32'd2, 1'b0, ERR_NONE};
          end else begin
            mode_nxt = M_DEAD;
            r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'd1, 1'b0, ERR_BANG};
          end
          n = 2'd1;
        end
        mode_r == M_STRING: begin
          if (b == CH_QUOTE) begin
            mode_nxt = M_IDLE;
            r[0] = '{1'b1, TK_STRING, 32'(OFFSET_BITS'(tstart_r + OFFSET_BITS'(1))),
                     32'(OFFSET_BITS'(len - OFFSET_BITS'(1))), 1'b0, ERR_NONE};
            n = 2'd1;
          end
        end
        mode_r == M_INT: begin
          if (is_digit(b)) begin
            // Overflow test: acc > (limit - d) / 10, limit - d in [L-9, L].
            if (iacc_r > INT_GUARD || (iacc_r == INT_GUARD && d > 4'd7)) begin
              ovf_nxt = 1'b1; iacc_nxt = {1'b0, I64_LIMIT};
            end else begin
              iacc_nxt = iacc_x10 + 64'(d);
            end
          end else if (b == CH_DOT) begin
            mode_nxt = M_INTDOT;
          end else if (ovf_r) begin
            mode_nxt = M_DEAD;
            r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'(len), 1'b0, ERR_OVF}; n = 2'd1;
          end else begin
            r[0] = '{1'b1, TK_INT, 32'(tstart_r), 32'(len), 1'b1, ERR_NONE}; n = 2'd1;
            restart = 1'b1;
          end
        end
        mode_r == M_INTDOT: begin
          if (is_digit(b)) begin
            mode_nxt = M_FRAC; facc_nxt = 64'(d); fcnt_nxt = 5'd1;
          end else if (ovf_r) begin
            mode_nxt = M_DEAD;
            r[0] = '{1'b1, TK_EOF, 32'(tstart_r), 32'(OFFSET_BITS'(pm1 - tstart_r)),
                     1'b0, ERR_OVF};
            n = 2'd1;
          end else begin
            r[0] = '{1'b1, TK_INT, 32'(tstart_r), 32'(OFFSET_BITS'(pm1 - tstart_r)),
                     1'b1, ERR_NONE};
            r[1] = '{1'b1, TK_DOT, 32'(pm1), 32'd1, 1'b0, ERR_NONE};
            n = 2'd2;
            restart = 1'b1;
          end
        end
        mode_r == M_FRAC: begin
          if (is_digit(b)) begin
            if (fcnt_r < 5'd18) begin
              facc_nxt = facc_x10 + 64'(d); fcnt_nxt = fcnt_r + 5'd1;
            end
          end else begin
            r[0] = '{1'b1, TK_DEC, 32'(tstart_r), 32'(len), 1'b1, ERR_NONE}; n = 2'd1;
            restart = 1'b1;
          end
        end
        mode_r == M_WORD: begin
          if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
            if (32'(len) < KEYWORD_MAX_CHARS) wbuf_nxt = {wbuf_r[WbBits-9:0], to_upper(b)};
            else wlong_nxt = 1'b1;
          end else begin
            r[0] = '{1'b1, kw_kind, 32'(tstart_r), 32'(len), 1'b0, ERR_NONE}; n = 2'd1;
            restart = 1'b1;
          end
        end
        default: mode_nxt = M_DEAD;
      endcase

      // Start a new token at this byte.
      if (restart) begin
        logic [5:0] pk;
        pk = TK_EOF;
        mode_nxt   = M_IDLE;
        tstart_nxt = p;
        unique case (b)
          8'h2C: pk = TK_COMMA;
          CH_DOT: pk = TK_DOT;
          8'h28: pk = TK_LPAR;
          8'h29: pk = TK_RPAR;
          8'h2B: pk = TK_PLUS;
          8'h2D: pk = TK_MINUS;
          8'h2A: pk = TK_STAR;
          8'h2F: pk = TK_SLASH;
          CH_EQ: pk = TK_EQ;
          default: pk = TK_EOF;
        endcase
        if (pk != TK_EOF) begin
          r[n] = '{1'b1, pk, 32'(p), 32'd1, 1'b0, ERR_NONE};
        end else if (b == CH_LT) begin
          mode_nxt = M_LT;
        end else if (b == CH_GT) begin
          mode_nxt = M_GT;
        end else if (b == CH_BANG) begin
          mode_nxt = M_BANG;
        end else if (b == CH_QUOTE) begin
          mode_nxt = M_STRING;
        end else if (is_space(b)) begin
          mode_nxt = M_IDLE;
        end else if (is_digit(b)) begin
          mode_nxt = M_INT; iacc_nxt = 64'(d); ovf_nxt = 1'b0;
          facc_nxt = '0; fcnt_nxt = '0;
        end else if (is_alpha(b) || b == CH_UNDER) begin
          mode_nxt = M_WORD; wbuf_nxt = WbBits'(to_upper(b)); wlong_nxt = 1'b0;
        end else begin
          mode_nxt = M_DEAD;
          r[n] = '{1'b1, TK_EOF, 32'(p), 32'd1, 1'b0, ERR_CHAR};
        end
      end
    end
  end

  // Results leave with the number state as it stands before the step.
  assign q_push = fire && (r[0].vld || r[1].vld || r[2].vld);
  assign q_req  = r;
  assign q_ival = iacc_r[62:0];
  assign q_fval = facc_r[59:0];
  assign q_fcnt = fcnt_r;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pos_r <= '0; tstart_r <= '0; iacc_r <= '0; facc_r <= '0;
      fcnt_r <= '0; wbuf_r <= '0; wlong_r <= 1'b0; ovf_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; tstart_r <= tstart_nxt;
      iacc_r <= iacc_nxt; facc_r <= facc_nxt; fcnt_r <= fcnt_nxt;
      wbuf_r <= wbuf_nxt; wlong_r <= wlong_nxt; ovf_r <= ovf_nxt;
    end
  end

  ap_len: assert property (@(posedge clk) disable iff (!rst_n)
    fire && r[1].vld |-> r[0].vld) else $error("request slots out of order");
  ap_dead: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_DEAD && fire && in_data.action == ACT_BYTE |=> mode_r == M_DEAD)
    else $error("left error mode without end");
  ap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.action == ACT_END |=> pos_r == '0) else $error("position kept");
endmodule

FILE: src/sts_back.sv
// Back end: queue of token groups and serializer onto the result channel.
module sts_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  sts_pkg::tok_req_t q_req [3],
  input  logic [62:0]       q_ival,
  input  logic [59:0]       q_fval,
  input  logic [4:0]        q_fcnt,
  output logic              q_room,
  output logic              out_valid,
  input  logic              out_ready,
  output sts_pkg::sts_out_t out_data
);
  import sts_pkg::*;

  localparam int Depth = 4;

  // Queue entries: one entry per result item, pushed up to three at once.
  sts_out_t          mem_r [Depth];
  logic [1:0]        wp_r, rp_r;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pop;
  logic [1:0]        npush;
  sts_out_t          e [3];
  logic [1:0]        lastidx;

  assign q_room = cnt_r <= 3'(Depth - 3) || (cnt_r == 3'(Depth - 2) && pop);
  assign pop    = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rp_r];

  // Build the result items of one group.
  always_comb begin
    npush   = 2'd0;
    lastidx = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (q_req[i].vld) begin
        npush   = npush + 2'd1;
        lastidx = 2'(i);
      end
    end
    for (int i = 0; i < 3; i++) begin
      e[i].token_kind   = q_req[i].kind;
      e[i].start_offset = q_req[i].start[15:0];
      e[i].token_length = q_req[i].len[15:0];
      e[i].int_value    = q_req[i].use_num ? q_ival : '0;
      e[i].frac_value   = (q_req[i].use_num && q_req[i].kind == TK_DEC) ? q_fval : '0;
      e[i].frac_digits  = (q_req[i].use_num && q_req[i].kind == TK_DEC) ? q_fcnt : '0;
      e[i].error_code   = q_req[i].err;
      e[i].last         = 2'(i) == lastidx;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r + (q_push ? 3'(npush) : 3'd0) - (pop ? 3'd1 : 3'd0);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (q_push) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < npush) mem_r[wp_r + 2'(i)] <= e[i];
      end
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (q_push) wp_r <= wp_r + npush;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  ap_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(Depth)) else $error("queue overrun");
  ap_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_room) else $error("push without room");
  ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !q_push && pop |=> cnt_r == $past(cnt_r) - 3'd1) else $error("count slip");
endmodule

FILE: src/sql_token_scanner.sv
// Top level of the SQL token scanner.
// Usage: query text enters on the in_ channel, one byte per item with
// action 0, closed by one item with action 1. Tokens leave on the out_
// channel in text order; each input item causes zero to three result
// items and the final one carries last = 1.
// Results of an item are written into the result queue when the item
// that completes them is accepted. Throughput: one input item per
// cycle while the queue has room; bytes are classified combinationally.
// A four-entry result queue sits between front and back. The front takes
// an item only while the queue has room for three more results, so input
// keeps flowing for a while when the receiver stalls, then in_ready drops.
// Reset empties the queue and returns the scanner to the idle mode with
// offset zero; after an end item the scanner resets the same way.
module sql_token_scanner #(
  parameter int OFFSET_BITS       = 16,
  parameter int KEYWORD_MAX_CHARS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sts_pkg::sts_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sts_pkg::sts_out_t out_data
);
  import sts_pkg::*;

  logic        q_push, q_room;
  tok_req_t    q_req [3];
  logic [62:0] q_ival;
  logic [59:0] q_fval;
  logic [4:0]  q_fcnt;

  // Front end: classification and token state.
  sts_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_push(q_push), .q_req(q_req), .q_ival(q_ival),
    .q_fval(q_fval), .q_fcnt(q_fcnt), .q_room(q_room)
  );

  // Back end: result queue.
  sts_back u_back (
    .clk(clk), .rst_n(rst_n), .q_push(q_push), .q_req(q_req), .q_ival(q_ival),
    .q_fval(q_fval), .q_fcnt(q_fcnt), .q_room(q_room), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );
endmodule
